>>> rtl/core/assert_macros.svh
// Assertion macros for the disc controller host port RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DCHP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define DCHP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dchp_pkg.sv
// Package for the disc controller host port: register and command codes,
// handshake state type and the fixed test response strings. No dependencies.
package dchp_pkg;

    // Access kinds.
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    // Register map.
    localparam logic [1:0] REG_STATUS  = 2'd0;
    localparam logic [1:0] REG_DATA    = 2'd1;
    localparam logic [1:0] REG_PARAM   = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    // Command indexes; indexes at or above CMD_COUNT are ignored.
    localparam logic [7:0] CMD_INIT  = 8'h0A;
    localparam logic [7:0] CMD_TEST  = 8'h19;
    localparam logic [7:0] CMD_COUNT = 8'd31;

    // Status values and byte masks.
    localparam logic [7:0] STAT_INIT_DONE = 8'h02;
    localparam logic [7:0] STAT_TEST_DONE = 8'h03;
    localparam logic [7:0] STAT_RESP_BIT  = 8'h20;
    localparam logic [7:0] STAT_FIXED_ONES = 8'h0F;
    localparam logic [7:0] HS_MAGIC       = 8'h07;
    localparam logic [7:0] CTRL_CLEAR     = 8'h00;
    localparam logic [7:0] CTRL_ARM       = 8'h01;

    // Response buffer geometry.
    localparam int unsigned RESP_DEPTH = 8;
    localparam logic [3:0]  RESP_END   = 4'd8;

    // Test subcodes and the strings they load.
    localparam logic [7:0] TEST_SUB_A = 8'h20;
    localparam logic [7:0] TEST_SUB_B = 8'h22;
    localparam logic [7:0] TEST_SUB_C = 8'h23;
    localparam logic [3:0] TEST_LEN_A = 4'd4;
    localparam logic [3:0] TEST_LEN_BC = 4'd8;

    localparam logic [0:7][7:0] TEST_BYTES_A =
        {8'h98, 8'h06, 8'h10, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [0:7][7:0] TEST_BYTES_B =
        {8'h66, 8'h6F, 8'h72, 8'h20, 8'h45, 8'h75, 8'h72, 8'h6F};
    localparam logic [0:7][7:0] TEST_BYTES_C =
        {8'h43, 8'h58, 8'h44, 8'h32, 8'h39, 8'h34, 8'h30, 8'h51};

    // Reset handshake sequencer.
    typedef enum logic [2:0] {
        HS_IDLE  = 3'b001,
        HS_ARMED = 3'b010,
        HS_READY = 3'b100
    } hs_state_t;

endpackage

>>> rtl/core/disc_controller_host_port_top.sv
// Top level of the disc controller host port: register decode, buffers and
// the reset handshake. Depends on dchp_pkg and assert_macros.svh.
//
//   Channel | Handshake                 | Beat payload
//   --------+---------------------------+------------------------------------
//   in      | in_valid  / in_stall out  | opcode, register_select, write_byte
//   out     | out_valid / out_stall in  | read_byte, command_interrupt
//
// One access is accepted every cycle while in_stall is low. An accepted access is
// loaded into the input register first and then into the result register, from
// which the result beat is taken.
// The valid bits and all port state clear on the asynchronous active-low rst_n.
// A stall on the out side holds the result register; the input register then
// stays full and in_stall rises until the result beat is taken.
`include "assert_macros.svh"

module disc_controller_host_port_top #(
    parameter int unsigned PARAM_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [1:0] register_select,
    input  logic [7:0] write_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_byte,
    output logic       command_interrupt
);

    localparam int unsigned PTR_W = $clog2(PARAM_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PARAM_DEPTH - 1);
    localparam int unsigned RESP_DEPTH_L = dchp_pkg::RESP_DEPTH;

    // Input beat register.
    logic       in_valid_reg;
    logic       opcode_reg;
    logic [1:0] reg_sel_reg;
    logic [7:0] wdata_reg;

    // Result beat register.
    logic       out_valid_reg;
    logic [7:0] read_byte_reg,  read_byte_next;
    logic       irq_reg,        irq_next;

    // Port state.
    logic [7:0]       param_buf_reg  [PARAM_DEPTH];
    logic [7:0]       param_buf_next [PARAM_DEPTH];
    logic [PTR_W-1:0] param_ptr_reg,  param_ptr_next;
    logic [7:0]       resp_buf_reg   [RESP_DEPTH_L];
    logic [7:0]       resp_buf_next  [RESP_DEPTH_L];
    logic [3:0]       resp_ptr_reg,   resp_ptr_next;
    logic [3:0]       resp_cnt_reg,   resp_cnt_next;
    logic             resp_rdy_reg,   resp_rdy_next;
    dchp_pkg::hs_state_t hs_reg,      hs_next;
    logic [7:0]       cmd_stat_reg,   cmd_stat_next;
    logic [7:0]       port_stat_reg,  port_stat_next;

    logic advance;
    logic in_take;
    logic [3:0] ptr_step;
    logic [0:7][7:0] load_bytes;
    logic [3:0] load_len;
    logic load_en;

    // Flow control: the input beat moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign out_valid         = out_valid_reg;
    assign read_byte         = read_byte_reg;
    assign command_interrupt = irq_reg;

    // Test string selection from the first parameter byte.
    always_comb
    begin
        load_bytes = dchp_pkg::TEST_BYTES_A;
        load_len   = dchp_pkg::TEST_LEN_A;
        load_en    = 1'b0;
        case (param_buf_reg[0])
            dchp_pkg::TEST_SUB_A:
            begin
                load_en = 1'b1;
            end
            dchp_pkg::TEST_SUB_B:
            begin
                load_bytes = dchp_pkg::TEST_BYTES_B;
                load_len   = dchp_pkg::TEST_LEN_BC;
                load_en    = 1'b1;
            end
            dchp_pkg::TEST_SUB_C:
            begin
                load_bytes = dchp_pkg::TEST_BYTES_C;
                load_len   = dchp_pkg::TEST_LEN_BC;
                load_en    = 1'b1;
            end
            default:
            begin
                load_en = 1'b0;
            end
        endcase
    end

    // Access decode and next state for the beat in the input register.
    always_comb
    begin
        param_buf_next = param_buf_reg;
        param_ptr_next = param_ptr_reg;
        resp_buf_next  = resp_buf_reg;
        resp_ptr_next  = resp_ptr_reg;
        resp_cnt_next  = resp_cnt_reg;
        resp_rdy_next  = resp_rdy_reg;
        hs_next        = hs_reg;
        cmd_stat_next  = cmd_stat_reg;
        port_stat_next = port_stat_reg;
        read_byte_next = 8'h00;
        irq_next       = 1'b0;
        ptr_step       = resp_ptr_reg;

        if (opcode_reg == dchp_pkg::ACC_READ)
        begin
            case (reg_sel_reg)
                dchp_pkg::REG_STATUS:
                begin
                    if (resp_rdy_reg && resp_cnt_reg != 4'd0)
                        port_stat_next = port_stat_reg | dchp_pkg::STAT_RESP_BIT;
                    else
                        port_stat_next = port_stat_reg & ~dchp_pkg::STAT_RESP_BIT;
                    read_byte_next = port_stat_next | dchp_pkg::STAT_FIXED_ONES;
                end
                dchp_pkg::REG_DATA:
                begin
                    // Drain one response byte; the pointer stops at the end.
                    if (resp_rdy_reg && resp_cnt_reg != 4'd0
                        && resp_ptr_reg != dchp_pkg::RESP_END)
                        read_byte_next = resp_buf_reg[resp_ptr_reg[2:0]];
                    if (resp_rdy_reg)
                    begin
                        if (resp_ptr_reg != dchp_pkg::RESP_END)
                            ptr_step = resp_ptr_reg + 4'd1;
                        resp_ptr_next = ptr_step;
                        if (ptr_step == resp_cnt_reg)
                            resp_rdy_next = 1'b0;
                    end
                end
                dchp_pkg::REG_CONTROL:
                begin
                    read_byte_next = cmd_stat_reg;
                end
                default:
                begin
                    read_byte_next = 8'h00;
                end
            endcase
        end
        else
        begin
            case (reg_sel_reg)
                dchp_pkg::REG_STATUS:
                begin
                    param_ptr_next = '0;
                    if (wdata_reg == dchp_pkg::CTRL_CLEAR)
                        resp_rdy_next = 1'b0;
                    else if (wdata_reg[0])
                        resp_rdy_next = 1'b1;
                    if (wdata_reg == dchp_pkg::CTRL_ARM)
                        hs_next = dchp_pkg::HS_ARMED;
                end
                dchp_pkg::REG_DATA:
                begin
                    // Command write: always interrupts, runs Init or Test.
                    irq_next = 1'b1;
                    if (wdata_reg < dchp_pkg::CMD_COUNT)
                    begin
                        if (wdata_reg == dchp_pkg::CMD_INIT)
                        begin
                            resp_ptr_next    = 4'd0;
                            resp_cnt_next    = 4'd1;
                            cmd_stat_next    = dchp_pkg::STAT_INIT_DONE;
                            resp_buf_next[0] = dchp_pkg::STAT_INIT_DONE;
                        end
                        else if (wdata_reg == dchp_pkg::CMD_TEST)
                        begin
                            cmd_stat_next = dchp_pkg::STAT_TEST_DONE;
                            if (load_en)
                            begin
                                resp_ptr_next = 4'd0;
                                resp_cnt_next = load_len;
                                for (int i = 0; i < RESP_DEPTH_L; i++)
                                begin
                                    if (4'(i) < load_len)
                                        resp_buf_next[i] = load_bytes[i];
                                end
                            end
                        end
                    end
                end
                dchp_pkg::REG_PARAM:
                begin
                    if (hs_reg == dchp_pkg::HS_READY && wdata_reg == dchp_pkg::HS_MAGIC)
                    begin
                        param_ptr_next = '0;
                        resp_rdy_next  = 1'b1;
                        hs_next        = dchp_pkg::HS_IDLE;
                        cmd_stat_next  = 8'h00;
                        port_stat_next = (resp_cnt_reg != 4'd0) ?
                                         dchp_pkg::STAT_RESP_BIT : 8'h00;
                    end
                    else
                    begin
                        hs_next = dchp_pkg::HS_IDLE;
                        param_buf_next[param_ptr_reg] = wdata_reg;
                        if (param_ptr_reg != PTR_LAST)
                            param_ptr_next = param_ptr_reg + PTR_W'(1);
                    end
                end
                dchp_pkg::REG_CONTROL:
                begin
                    if (wdata_reg == dchp_pkg::HS_MAGIC && hs_reg == dchp_pkg::HS_ARMED)
                        hs_next = dchp_pkg::HS_READY;
                    else
                        hs_next = dchp_pkg::HS_IDLE;
                end
                default:
                begin
                    hs_next = hs_reg;
                end
            endcase
        end
    end

    // Input beat register: control bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input beat register: payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg  <= opcode;
            reg_sel_reg <= register_select;
            wdata_reg   <= write_byte;
        end
    end

    // Result beat register: control bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result beat register: payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_byte_reg <= read_byte_next;
            irq_reg       <= irq_next;
        end
    end

    // Port state, updated once per processed beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PARAM_DEPTH; i++)
                param_buf_reg[i] <= 8'h00;
            for (int i = 0; i < RESP_DEPTH_L; i++)
                resp_buf_reg[i] <= 8'h00;
            param_ptr_reg <= '0;
            resp_ptr_reg  <= 4'd0;
            resp_cnt_reg  <= 4'd0;
            resp_rdy_reg  <= 1'b0;
            hs_reg        <= dchp_pkg::HS_IDLE;
            cmd_stat_reg  <= 8'h00;
            port_stat_reg <= 8'h00;
        end
        else if (advance)
        begin
            param_buf_reg <= param_buf_next;
            resp_buf_reg  <= resp_buf_next;
            param_ptr_reg <= param_ptr_next;
            resp_ptr_reg  <= resp_ptr_next;
            resp_cnt_reg  <= resp_cnt_next;
            resp_rdy_reg  <= resp_rdy_next;
            hs_reg        <= hs_next;
            cmd_stat_reg  <= cmd_stat_next;
            port_stat_reg <= port_stat_next;
        end
    end

    // Checks on the buffer bookkeeping, the result beat and the input stall.
    `DCHP_ASSERT_ALWAYS(a_resp_ptr_range, resp_ptr_reg <= dchp_pkg::RESP_END, "response pointer past end")
    `DCHP_ASSERT_ALWAYS(a_resp_cnt_range, resp_cnt_reg <= dchp_pkg::RESP_END, "response count past end")
    `DCHP_ASSERT_IMPLY(a_irq_no_data, out_valid_reg && irq_reg, read_byte_reg == 8'h00, "interrupt beat carries data")
    `DCHP_ASSERT_IMPLY(a_stall_full, in_stall, in_valid_reg && out_valid_reg && out_stall, "input stalled without back pressure")

endmodule
